### sv/rc_line_classifier_defines.svh
// Assertion macros used by the checker file.
`ifndef RC_LINE_CLASSIFIER_DEFINES_SVH
`define RC_LINE_CLASSIFIER_DEFINES_SVH

// Check a property at every rising edge outside reset.
`define RCLC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check an implication at every rising edge outside reset.
`define RCLC_ASSERT_IMPL(label, pre, post, msg) \
  `RCLC_ASSERT(label, (pre) |-> (post), msg)

`endif

### sv/rclc_pkg.sv
`timescale 1ns / 1ps
package rclc_pkg;

  localparam int unsigned POS_W   = 12;
  localparam int unsigned POS_CAP = 4095;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_H     = 8'h48;

  localparam logic [1:0] CLS_IGNORE  = 2'd0;
  localparam logic [1:0] CLS_PATH    = 2'd1;
  localparam logic [1:0] CLS_COMMAND = 2'd2;

  typedef enum logic [3:0] {
    KIND_WS,
    KIND_HASH,
    KIND_EQ,
    KIND_P,
    KIND_A,
    KIND_T,
    KIND_H,
    KIND_NUL,
    KIND_OTHER
  } byte_kind_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       line_class;
    logic [POS_W-1:0] value_offset;
  } out_item_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic       eol;
    byte_kind_e kind;
  } tok_t;

endpackage

### sv/rclc_fifo.sv
`timescale 1ns / 1ps
module rclc_fifo
  import rclc_pkg::*;
#(
  parameter int unsigned Width = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  logic [Width-1:0]  mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### sv/rclc_front.sv
`timescale 1ns / 1ps
module rclc_front
  import rclc_pkg::*;
(
  input  in_item_t item_i,
  output tok_t     tok_o
);

  logic [7:0] b;
  logic       is_ws;

  assign b     = item_i.char_byte;
  // space, or tab through carriage return
  assign is_ws = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));

  always_comb begin
    tok_o.eol = item_i.end_of_line;
    priority if (b == CHAR_NUL) begin
      tok_o.kind = KIND_NUL;
    end else if (is_ws) begin
      tok_o.kind = KIND_WS;
    end else if (b == CHAR_HASH) begin
      tok_o.kind = KIND_HASH;
    end else if (b == CHAR_EQ) begin
      tok_o.kind = KIND_EQ;
    end else if (b == CHAR_P) begin
      tok_o.kind = KIND_P;
    end else if (b == CHAR_A) begin
      tok_o.kind = KIND_A;
    end else if (b == CHAR_T) begin
      tok_o.kind = KIND_T;
    end else if (b == CHAR_H) begin
      tok_o.kind = KIND_H;
    end else begin
      tok_o.kind = KIND_OTHER;
    end
  end

endmodule

### sv/rclc_back.sv
`timescale 1ns / 1ps
module rclc_back
  import rclc_pkg::*;
#(
  parameter int unsigned LineMaxBytes = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tok_t      tok_i,
  input  logic      tok_valid_i,
  output logic      tok_pop_o,
  input  logic      res_full_i,
  output logic      res_push_o,
  output out_item_t res_o
);

  localparam int unsigned PosMaxInt =
    ((LineMaxBytes - 1) < POS_CAP) ? (LineMaxBytes - 1) : POS_CAP;
  localparam logic [POS_W-1:0] PosMax = POS_W'(PosMaxInt);

  typedef enum logic [11:0] {
    ST_LEAD = 12'b0000_0000_0001,
    ST_P1   = 12'b0000_0000_0010,
    ST_P2   = 12'b0000_0000_0100,
    ST_P3   = 12'b0000_0000_1000,
    ST_P4   = 12'b0000_0001_0000,
    ST_PWS  = 12'b0000_0010_0000,
    ST_PEQ  = 12'b0000_0100_0000,
    ST_TOK  = 12'b0000_1000_0000,
    ST_TWS  = 12'b0001_0000_0000,
    ST_CMD  = 12'b0010_0000_0000,
    ST_IGN  = 12'b0100_0000_0000,
    ST_PATH = 12'b1000_0000_0000
  } state_e;

  state_e           st_q, st_d, tok_next;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] vs_q, vs_d;
  logic             take;
  byte_kind_e       k;

  assign k = tok_i.kind;
  // An end-of-line item waits until the result queue has room.
  assign take       = tok_valid_i && (!tok_i.eol || !res_full_i);
  assign tok_pop_o  = take;
  assign res_push_o = take && tok_i.eol;

  // Ordinary token byte after the first one.
  always_comb begin
    unique case (k)
      KIND_WS: tok_next = ST_TWS;
      KIND_EQ: tok_next = ST_IGN;
      default: tok_next = ST_TOK;
    endcase
  end

  always_comb begin
    res_o.line_class   = CLS_COMMAND;
    res_o.value_offset = vs_q;
    unique case (st_q)
      ST_LEAD, ST_IGN: begin
        res_o.line_class   = CLS_IGNORE;
        res_o.value_offset = '0;
      end
      ST_PEQ: begin
        res_o.line_class   = CLS_PATH;
        res_o.value_offset = pos_q;
      end
      ST_PATH: res_o.line_class = CLS_PATH;
      default: res_o.line_class = CLS_COMMAND;
    endcase
  end

  always_comb begin
    st_d  = st_q;
    pos_d = pos_q;
    vs_d  = vs_q;
    if (take) begin
      if (tok_i.eol) begin
        st_d  = ST_LEAD;
        pos_d = '0;
        vs_d  = '0;
      end else begin
        pos_d = (pos_q < PosMax) ? pos_q + 1'b1 : PosMax;
        if (k == KIND_NUL) begin
          // zero byte closes the content; drop everything up to end of line
          unique case (st_q)
            ST_LEAD: st_d = ST_IGN;
            ST_PEQ: begin
              vs_d = pos_q;
              st_d = ST_PATH;
            end
            ST_IGN, ST_PATH: st_d = st_q;
            default: st_d = ST_CMD;
          endcase
        end else begin
          unique case (st_q)
            ST_LEAD: begin
              if (k != KIND_WS) begin
                vs_d = pos_q;
                if (k == KIND_HASH || k == KIND_EQ) begin
                  st_d = ST_IGN;
                end else if (k == KIND_P) begin
                  st_d = ST_P1;
                end else begin
                  st_d = ST_TOK;
                end
              end
            end
            ST_P1: st_d = (k == KIND_A) ? ST_P2 : tok_next;
            ST_P2: st_d = (k == KIND_T) ? ST_P3 : tok_next;
            ST_P3: st_d = (k == KIND_H) ? ST_P4 : tok_next;
            ST_P4: begin
              if (k == KIND_WS) begin
                st_d = ST_PWS;
              end else if (k == KIND_EQ) begin
                st_d = ST_PEQ;
              end else begin
                st_d = ST_TOK;
              end
            end
            ST_PWS: begin
              if (k == KIND_EQ) begin
                st_d = ST_PEQ;
              end else if (k != KIND_WS) begin
                st_d = ST_CMD;
              end
            end
            ST_PEQ: begin
              if (k != KIND_WS) begin
                vs_d = pos_q;
                st_d = ST_PATH;
              end
            end
            ST_TOK: st_d = tok_next;
            ST_TWS: begin
              if (k == KIND_EQ) begin
                st_d = ST_IGN;
              end else if (k != KIND_WS) begin
                st_d = ST_CMD;
              end
            end
            ST_CMD, ST_IGN, ST_PATH: st_d = st_q;
            default: st_d = ST_CMD;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_LEAD;
      pos_q <= '0;
      vs_q  <= '0;
    end else begin
      st_q  <= st_d;
      pos_q <= pos_d;
      vs_q  <= vs_d;
    end
  end

endmodule

### sv/rc_line_classifier.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+------------------------------------
// bytes    | in        | push_i / full_o     | in_item_i  {char_byte, end_of_line}
// results  | out       | empty_o / pop_i     | out_item_o {line_class, value_offset}
//
// Throughput is one item per cycle unless the parser stalls; the parser state
// machine decides one classified byte per cycle, but an end-of-line item waits
// in the middle queue while the result queue is full, then its result is queued.
// Reset clears both queues and the parser; no clearing pass is needed.
// full_o rises only when the result queue is full and an end-of-line item
// waits with one more item behind it; empty_o low holds the oldest result.
module rc_line_classifier
  import rclc_pkg::*;
#(
  parameter int unsigned LINE_MAX_BYTES = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  output logic      full_o,
  input  in_item_t  in_item_i,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t out_item_o
);

  localparam int unsigned TokW = $bits(tok_t);
  localparam int unsigned OutW = $bits(out_item_t);

  tok_t            front_tok;
  logic [TokW-1:0] mid_data;
  tok_t            mid_tok;
  logic            mid_empty;
  logic            mid_pop;
  logic            res_full;
  logic            res_push;
  out_item_t       res_item;
  logic [OutW-1:0] out_data;

  // Classify each byte as it arrives.
  rclc_front u_front (
    .item_i (in_item_i),
    .tok_o  (front_tok)
  );

  // Hold classified items so input is still taken while the parser stalls, until this queue fills.
  rclc_fifo #(
    .Width (TokW)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (front_tok),
    .full_o  (full_o),
    .pop_i   (mid_pop),
    .data_o  (mid_data),
    .empty_o (mid_empty)
  );

  assign mid_tok = tok_t'(mid_data);

  // Advance the line parser and emit one result per line.
  rclc_back #(
    .LineMaxBytes (LINE_MAX_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (mid_tok),
    .tok_valid_i (!mid_empty),
    .tok_pop_o   (mid_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_item)
  );

  // Hold finished results until the consumer pops them.
  rclc_fifo #(
    .Width (OutW)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_item),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .data_o  (out_data),
    .empty_o (empty_o)
  );

  assign out_item_o = out_item_t'(out_data);

endmodule

### sv/rclc_checker.sv
`timescale 1ns / 1ps
`include "rc_line_classifier_defines.svh"
module rclc_checker
  import rclc_pkg::*;
#(
  parameter int unsigned LINE_MAX_BYTES = 4096
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      push_i,
  input logic      full_o,
  input in_item_t  in_item_i,
  input logic      empty_o,
  input logic      pop_i,
  input out_item_t out_item_o
);

  localparam int unsigned PosMaxInt =
    ((LINE_MAX_BYTES - 1) < POS_CAP) ? (LINE_MAX_BYTES - 1) : POS_CAP;
  localparam logic [POS_W-1:0] PosMax = POS_W'(PosMaxInt);

  `RCLC_ASSERT_IMPL(a_class_legal, !empty_o, out_item_o.line_class != 2'd3, "bad line class")
  `RCLC_ASSERT_IMPL(a_ignore_zero, !empty_o && out_item_o.line_class == CLS_IGNORE, out_item_o.value_offset == '0, "ignored line with offset")
  `RCLC_ASSERT_IMPL(a_offset_sat, !empty_o, out_item_o.value_offset <= PosMax, "offset past saturation")
  `RCLC_ASSERT(a_result_holds, (!empty_o && !pop_i) |=> (!empty_o && $stable(out_item_o)), "waiting result changed")

endmodule

bind rc_line_classifier rclc_checker #(
  .LINE_MAX_BYTES (LINE_MAX_BYTES)
) u_rclc_checker (.*);

### dv/tb.sv
`timescale 1ns / 1ps
module tb
  import rclc_pkg::*;
();

  localparam int unsigned LINE_BYTES = 4096;
  localparam int unsigned POS_LIMIT  = (LINE_BYTES - 1 < POS_CAP) ? LINE_BYTES - 1 : POS_CAP;
  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned QUIET_FROM   = 1150;
  localparam logic [31:0] PATH_WORD = {CHAR_P, CHAR_A, CHAR_T, CHAR_H};

  // Parser states of the line classifier, as the predictor tracks them.
  typedef enum logic [3:0] {
    PS_LEAD,  // skipping leading whitespace
    PS_P1,    // seen "P"
    PS_P2,    // seen "PA"
    PS_P3,    // seen "PAT"
    PS_P4,    // seen "PATH"
    PS_PWS,   // "PATH" then whitespace
    PS_PEQ,   // "PATH" ... '=' then whitespace, value not started yet
    PS_TOK,   // inside the first token, no '=' yet
    PS_TWS,   // whitespace after the first token, no '=' yet
    PS_CMD,   // settled: command
    PS_IGN,   // settled: ignore
    PS_PATH   // settled: path directive
  } parse_state_e;

  // Tracks the line being parsed and the verdicts still owed by the block.
  class line_scoreboard;
    out_item_t        verdicts_q[$];
    parse_state_e     state;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] value_pos;
    int unsigned      errors;

    function new();
      errors = 0;
      clear_line();
    endfunction

    function void clear_line();
      state     = PS_LEAD;
      pos       = '0;
      value_pos = '0;
    endfunction

    function int unsigned lines_in_flight();
      return verdicts_q.size();
    endfunction

    static function bit is_space(logic [7:0] b);
      return b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR);
    endfunction

    static function parse_state_e after_token(logic [7:0] b);
      if (is_space(b)) return PS_TWS;
      if (b == CHAR_EQ) return PS_IGN;
      return PS_TOK;
    endfunction

    function void note_item(in_item_t it);
      logic [7:0] b;
      out_item_t  verdict;
      b = it.char_byte;
      if (it.end_of_line) begin
        case (state)
          PS_LEAD, PS_IGN: begin
            verdict.line_class   = CLS_IGNORE;
            verdict.value_offset = '0;
          end
          PS_PEQ: begin
            verdict.line_class   = CLS_PATH;
            verdict.value_offset = pos;
          end
          PS_PATH: begin
            verdict.line_class   = CLS_PATH;
            verdict.value_offset = value_pos;
          end
          default: begin
            verdict.line_class   = CLS_COMMAND;
            verdict.value_offset = value_pos;
          end
        endcase
        verdicts_q.push_back(verdict);
        clear_line();
        return;
      end
      if (b == CHAR_NUL) begin
        // A zero byte closes the content; later bytes cannot change the verdict.
        case (state)
          PS_LEAD: state = PS_IGN;
          PS_PEQ: begin
            value_pos = pos;
            state     = PS_PATH;
          end
          PS_IGN, PS_PATH: ;
          default: state = PS_CMD;
        endcase
      end else begin
        case (state)
          PS_LEAD: begin
            if (!is_space(b)) begin
              value_pos = pos;
              if (b == CHAR_HASH || b == CHAR_EQ) state = PS_IGN;
              else if (b == CHAR_P) state = PS_P1;
              else state = PS_TOK;
            end
          end
          PS_P1: state = (b == CHAR_A) ? PS_P2 : after_token(b);
          PS_P2: state = (b == CHAR_T) ? PS_P3 : after_token(b);
          PS_P3: state = (b == CHAR_H) ? PS_P4 : after_token(b);
          PS_P4: begin
            if (is_space(b)) state = PS_PWS;
            else if (b == CHAR_EQ) state = PS_PEQ;
            else state = PS_TOK;
          end
          PS_PWS: begin
            if (b == CHAR_EQ) state = PS_PEQ;
            else if (!is_space(b)) state = PS_CMD;
          end
          PS_PEQ: begin
            if (!is_space(b)) begin
              value_pos = pos;
              state     = PS_PATH;
            end
          end
          PS_TOK: state = after_token(b);
          PS_TWS: begin
            if (b == CHAR_EQ) state = PS_IGN;
            else if (!is_space(b)) state = PS_CMD;
          end
          default: ;
        endcase
      end
      if (pos < POS_LIMIT) pos = pos + 1'b1;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (verdicts_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual class %0d offset %0d",
                 $time, got.line_class, got.value_offset);
        return;
      end
      want = verdicts_q.pop_front();
      if (got.line_class !== want.line_class) begin
        errors++;
        $display("%0t: line_class mismatch, expected %0d, actual %0d",
                 $time, want.line_class, got.line_class);
      end
      if (got.value_offset !== want.value_offset) begin
        errors++;
        $display("%0t: value_offset mismatch, expected %0d, actual %0d",
                 $time, want.value_offset, got.value_offset);
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni    = 1'b0;
  logic      push_i    = 1'b0;
  in_item_t  in_item_i = '0;
  logic      pop_i     = 1'b0;
  logic      full_o;
  logic      empty_o;
  out_item_t out_item_o;

  line_scoreboard sb = new();

  logic [7:0]  line_buf[$];
  int unsigned items_sent = 0;
  bit          quiet_tail = 1'b0;
  bit          long_done  = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned long_hold_left = 0;
  int unsigned burst_left     = 0;

  rc_line_classifier #(
    .LINE_MAX_BYTES(LINE_BYTES)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .full_o    (full_o),
    .in_item_i (in_item_i),
    .empty_o   (empty_o),
    .pop_i     (pop_i),
    .out_item_o(out_item_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watch both handshakes at the edge; values seen here are the ones the block sampled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push_i && !full_o) sb.note_item(in_item_i);
      if (pop_i && !empty_o) sb.check_result(out_item_o);
    end
  end

  // Result side: random bursts of stalls, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop_i <= 1'b0;
    end else if (hold_requests != hold_served) begin
      // Hold off long enough for the result queue to fill and back up the input.
      hold_served    <= hold_requests;
      long_hold_left <= 400;
      pop_i          <= 1'b0;
    end else if (long_hold_left != 0) begin
      long_hold_left <= long_hold_left - 1;
      pop_i          <= 1'b0;
    end else if (burst_left != 0) begin
      burst_left <= burst_left - 1;
      pop_i      <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      burst_left <= $urandom_range(1, 16) - 1;
      pop_i      <= 1'b0;
    end else begin
      pop_i <= 1'b1;
    end
  end

  // Offer one item and hold it until the block takes it; idle now and then afterwards.
  task automatic send_item(input logic [7:0] b, input logic eol);
    in_item_t it;
    it.char_byte   = b;
    it.end_of_line = eol;
    push_i    <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full_o);
    items_sent++;
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      push_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  // Send the buffered bytes, then the end-of-line item with a junk byte.
  task automatic send_line();
    foreach (line_buf[i]) send_item(line_buf[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
    line_buf.delete();
  endtask

  // Stop offering and wait until every owed verdict has come back.
  // Step one edge first so the last accepted item is noted before counting.
  task automatic wait_drained();
    push_i <= 1'b0;
    @(posedge clk_i);
    while (sb.lines_in_flight() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_space();
    if ($urandom_range(0, 2) == 0) return CHAR_SPACE;
    return CHAR_TAB + 8'($urandom_range(0, 4));
  endfunction

  // Token byte: printable, never '=', often one of the letters of PATH.
  function automatic logic [7:0] rand_token_byte();
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0) return PATH_WORD[8*$urandom_range(0, 3) +: 8];
    do b = 8'($urandom_range(33, 126)); while (b == CHAR_EQ);
    return b;
  endfunction

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic push_space(input int unsigned n);
    repeat (n) line_buf.push_back(rand_space());
  endtask

  task automatic push_token(input int unsigned n);
    repeat (n) line_buf.push_back(rand_token_byte());
  endtask

  task automatic push_value(input int unsigned n);
    repeat (n) line_buf.push_back(8'($urandom_range(1, 255)));
  endtask

  // Build one random line, mostly well-formed with random content.
  task automatic build_random_line();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 9);
    push_space($urandom_range(0, 3));
    case (kind)
      0, 1: begin
        push_str("PATH");
        push_space($urandom_range(0, 2));
        line_buf.push_back(CHAR_EQ);
        push_space($urandom_range(0, 2));
        push_value($urandom_range(0, 8));
      end
      2: begin
        // Partial or spoiled PATH prefix.
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) line_buf.push_back(PATH_WORD[31-8*i -: 8]);
        case ($urandom_range(0, 3))
          0: line_buf.push_back(rand_token_byte());
          1: push_space($urandom_range(1, 2));
          2: line_buf.push_back(CHAR_EQ);
          default: ;
        endcase
        case ($urandom_range(0, 2))
          0: line_buf.push_back(CHAR_EQ);
          1: begin
            line_buf.push_back(rand_token_byte());
            line_buf.push_back(CHAR_EQ);
          end
          default: ;
        endcase
        push_value($urandom_range(0, 5));
      end
      3: begin
        push_token($urandom_range(0, 5));
        push_space($urandom_range(0, 2));
        line_buf.push_back(CHAR_EQ);
        push_value($urandom_range(0, 6));
      end
      4: begin
        line_buf.push_back(CHAR_HASH);
        push_value($urandom_range(0, 8));
      end
      5, 6: begin
        push_token($urandom_range(1, 6));
        push_space($urandom_range(0, 2));
        if ($urandom_range(0, 1) == 0) push_token($urandom_range(1, 4));
        push_value($urandom_range(0, 6));
      end
      7: ;
      default: begin
        // Noise: any byte value.
        repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
      end
    endcase
    if (line_buf.size() != 0 && $urandom_range(0, 9) == 0)
      line_buf[$urandom_range(0, line_buf.size() - 1)] = CHAR_NUL;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines: every class, the PATH near misses, zero bytes, extreme byte values.
    send_line();
    push_str("PATH=x");                          send_line();
    push_str(" \tPATH  =  /usr");                send_line();
    push_str("PATH = \t");                       send_line();
    push_str("#PATH=x");                         send_line();
    push_str("=abc");                            send_line();
    push_str("PATHX=1");                         send_line();
    push_str("PATH x=1");                        send_line();
    push_str("  run fast");                      send_line();
    push_str("ab \t= c");                        send_line();
    push_str("PA");                              send_line();
    push_str("PATH");                            send_line();
    push_str(" \r ");                            send_line();
    line_buf.push_back(CHAR_NUL); push_str("abc"); send_line();
    push_str("PATH= "); line_buf.push_back(CHAR_NUL); push_str("x"); send_line();
    push_str("ab"); line_buf.push_back(CHAR_NUL); push_str("=c"); send_line();
    line_buf.push_back(8'hFF); line_buf.push_back(8'h80); send_line();

    // Pause the sender until every verdict is back.
    wait_drained();

    // Long receiver hold-off while short lines keep coming, so the input stalls.
    hold_requests <= hold_requests + 1;
    repeat (40) send_line();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (!long_done && items_sent > 500) begin
        // Longer lines: offsets well above the short-line range.
        long_done = 1'b1;
        wait_drained();
        push_space(100); push_str("go");         send_line();
        push_str("PATH="); push_space(100);      send_line();
        push_str("PATH = v"); push_value(100);   send_line();
      end
      if (items_sent > QUIET_FROM) quiet_tail = 1'b1;
      build_random_line();
      send_line();
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.lines_in_flight() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/rclc_pkg.sv
sv/rclc_fifo.sv
sv/rclc_front.sv
sv/rclc_back.sv
sv/rc_line_classifier.sv
sv/rclc_checker.sv
dv/tb.sv
